@@ rtl/bitmap_glyph_row_renderer_defines.svh @@
// Assertion macros for the glyph row renderer RTL, used by the row sequencer.
`ifndef BITMAP_GLYPH_ROW_RENDERER_DEFINES_SVH
`define BITMAP_GLYPH_ROW_RENDERER_DEFINES_SVH

`ifndef ASSERT_OFF
`define BGRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BGRR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BGRR_ASSERT(lbl, prop, msg)
`define BGRR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/bgrr_pkg.sv @@
// Types and constants of the glyph row renderer.
`default_nettype none
package bgrr_pkg;

  localparam int unsigned BASE_W   = 48;
  localparam int unsigned SIZE_W   = 29;
  localparam int unsigned PPL_W    = 14;
  localparam int unsigned STRIDE_W = 6;
  localparam int unsigned CFG_W    = 48;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned GLYPH_W = 8;
  localparam int unsigned ADDR_W  = 49;

  localparam int unsigned LINE_W  = 13;
  localparam int unsigned PROD_W  = 27;
  localparam int unsigned OFF_W   = 30;
  localparam int unsigned FADDR_W = 16;
  localparam int unsigned BPP_SH  = 2;

  localparam logic [BASE_W-1:0]   BASE_RST   = '0;
  localparam logic [SIZE_W-1:0]   SIZE_RST   = SIZE_W'(4194304);
  localparam logic [PPL_W-1:0]    PPL_RST    = PPL_W'(1024);
  localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(16);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_BASE = 2'd0,
    REG_FRAME_SIZE = 2'd1,
    REG_PPL        = 2'd2,
    REG_STRIDE     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic [LINE_W-1:0]   line;
    logic [POS_W-1:0]    x;
    logic [COLOR_W-1:0]  color;
  } row_issue_t;

endpackage
`default_nettype wire

@@ rtl/bgrr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bgrr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bgrr_seq.sv @@
// Input beat handling and row sequencer: font loads and per-row store reads.
`default_nettype none
`include "bitmap_glyph_row_renderer_defines.svh"
module bgrr_seq #(
  parameter int unsigned FONT_BYTES = 8192,
  parameter int unsigned GLYPH_ROWS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             command_i,
  input  wire logic [$clog2(FONT_BYTES)-1:0]    font_addr_i,
  input  wire logic [bgrr_pkg::GLYPH_W-1:0]     font_byte_i,
  input  wire logic [bgrr_pkg::CODE_W-1:0]      char_code_i,
  input  wire logic [bgrr_pkg::POS_W-1:0]       x_pos_i,
  input  wire logic [bgrr_pkg::POS_W-1:0]       y_pos_i,
  input  wire logic [bgrr_pkg::COLOR_W-1:0]     color_i,
  input  wire logic [bgrr_pkg::STRIDE_W-1:0]    stride_i,
  input  wire logic                             adv_i,
  output logic                                  ram_we_o,
  output logic      [$clog2(FONT_BYTES)-1:0]    ram_waddr_o,
  output logic      [bgrr_pkg::GLYPH_W-1:0]     ram_wdata_o,
  output logic                                  ram_re_o,
  output logic      [$clog2(FONT_BYTES)-1:0]    ram_raddr_o,
  output bgrr_pkg::row_issue_t                  issue_o
);
  import bgrr_pkg::*;

  localparam int unsigned AW = $clog2(FONT_BYTES);
  localparam int unsigned RW = $clog2(GLYPH_ROWS);
  localparam logic [RW-1:0] LastRow = RW'(GLYPH_ROWS - 1);

  logic               busy_q, busy_d;
  logic [RW-1:0]      row_q, row_d;
  logic [FADDR_W-1:0] fbase_q, fbase_d;
  logic [FADDR_W-1:0] faddr;
  logic [POS_W-1:0]   x_q, y_q;
  logic [COLOR_W-1:0] color_q;
  logic               accept, start, issue, last;

  assign last       = (row_q == LastRow);
  assign issue      = busy_q && adv_i;
  assign in_stall_o = busy_q && !(adv_i && last);
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = accept && (command_i == CMD_DRAW) && (char_code_i != '0);

  assign ram_we_o    = accept && (command_i == CMD_LOAD);
  assign ram_waddr_o = font_addr_i;
  assign ram_wdata_o = font_byte_i;

  assign faddr       = fbase_q + FADDR_W'(row_q);
  assign ram_re_o    = issue;
  assign ram_raddr_o = faddr[AW-1:0];

  assign fbase_d = FADDR_W'(char_code_i) * FADDR_W'(stride_i);

  assign issue_o.valid = issue;
  assign issue_o.last  = last;
  assign issue_o.line  = LINE_W'(y_q) + LINE_W'(row_q);
  assign issue_o.x     = x_q;
  assign issue_o.color = color_q;

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    if (start) begin
      busy_d = 1'b1;
      row_d  = '0;
    end else if (issue) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        row_d = row_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      fbase_q <= fbase_d;
      x_q     <= x_pos_i;
      y_q     <= y_pos_i;
      color_q <= color_i;
    end
  end

  `BGRR_ASSERT(a_draw_starts, start |=> (busy_q && row_q == '0), "draw beat did not start rows")
  `BGRR_ASSERT(a_row_hold, (busy_q && !adv_i) |=> $stable(row_q), "row moved during stall")
  `BGRR_ASSERT(a_done, (issue && last && !start) |=> !busy_q, "sequencer busy after last row")
  `BGRR_ASSERT_NEVER(a_no_wr_busy, ram_we_o && busy_q && !(adv_i && last),
                     "font load taken while rows pending")

endmodule
`default_nettype wire

@@ rtl/bgrr_pipe.sv @@
// Row datapath: line product, byte offset, then address and clipped mask.
`default_nettype none
module bgrr_pipe (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire bgrr_pkg::row_issue_t          issue_i,
  input  wire logic [bgrr_pkg::GLYPH_W-1:0]  font_rdata_i,
  input  wire logic [bgrr_pkg::BASE_W-1:0]   frame_base_i,
  input  wire logic [bgrr_pkg::SIZE_W-1:0]   frame_size_i,
  input  wire logic [bgrr_pkg::PPL_W-1:0]    ppl_i,
  output logic                               out_valid_o,
  output logic      [bgrr_pkg::ADDR_W-1:0]   row_address_o,
  output logic      [bgrr_pkg::GLYPH_W-1:0]  pixel_mask_o,
  output logic      [bgrr_pkg::COLOR_W-1:0]  pixel_color_o,
  output logic                               last_row_o
);
  import bgrr_pkg::*;

  // stage 1: row issued, font byte arrives from the store
  logic               s1_valid_q, s1_last_q;
  logic [LINE_W-1:0]  s1_line_q;
  logic [POS_W-1:0]   s1_x_q;
  logic [COLOR_W-1:0] s1_color_q;
  // stage 2: line * pixels per line
  logic               s2_valid_q, s2_last_q;
  logic [PROD_W-1:0]  s2_prod_q, s2_prod_d;
  logic [POS_W-1:0]   s2_x_q;
  logic [COLOR_W-1:0] s2_color_q;
  logic [GLYPH_W-1:0] s2_bits_q;
  // stage 3: byte offset of the row
  logic               s3_valid_q, s3_last_q;
  logic [OFF_W-1:0]   s3_off_q, s3_off_d;
  logic [COLOR_W-1:0] s3_color_q;
  logic [GLYPH_W-1:0] s3_bits_q;
  // output stage
  logic               out_valid_q, out_last_q;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic [GLYPH_W-1:0] out_mask_q, out_mask_d;
  logic [COLOR_W-1:0] out_color_q;

  assign s2_prod_d = PROD_W'(s1_line_q) * PROD_W'(ppl_i);
  assign s3_off_d  = OFF_W'({s2_x_q, 2'b00}) + OFF_W'({s2_prod_q, 2'b00});
  assign out_addr_d = ADDR_W'(frame_base_i) + ADDR_W'(s3_off_q);

  always_comb begin
    logic [OFF_W:0] pix_off;
    out_mask_d = '0;
    for (int c = 0; c < GLYPH_W; c++) begin
      pix_off = (OFF_W+1)'(s3_off_q) + (OFF_W+1)'(c << BPP_SH);
      out_mask_d[GLYPH_W-1-c] = s3_bits_q[GLYPH_W-1-c] &&
                                (pix_off < (OFF_W+1)'(frame_size_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q  <= issue_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_last_q   <= issue_i.last;
      s1_line_q   <= issue_i.line;
      s1_x_q      <= issue_i.x;
      s1_color_q  <= issue_i.color;
      s2_last_q   <= s1_last_q;
      s2_prod_q   <= s2_prod_d;
      s2_x_q      <= s1_x_q;
      s2_color_q  <= s1_color_q;
      s2_bits_q   <= font_rdata_i;
      s3_last_q   <= s2_last_q;
      s3_off_q    <= s3_off_d;
      s3_color_q  <= s2_color_q;
      s3_bits_q   <= s2_bits_q;
      out_last_q  <= s3_last_q;
      out_addr_q  <= out_addr_d;
      out_mask_q  <= out_mask_d;
      out_color_q <= s3_color_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_address_o = out_addr_q;
  assign pixel_mask_o  = out_mask_q;
  assign pixel_color_o = out_color_q;
  assign last_row_o    = out_last_q;

endmodule
`default_nettype wire

@@ rtl/bitmap_glyph_row_renderer.sv @@
// Top level of the glyph row renderer: config registers, sequencer, store, datapath.
// Draw beat: GLYPH_ROWS result beats, one per cycle while the output is not stalled, one font store read per row.
// A draw stalls the input while its rows are issued; the next beat is taken with the last row.
// First row passes the row sequencer, then stages 1 to 3 and the output stage; loads and zero codes do not stall.
// An output stall with a valid row freezes the whole row pipeline in place.
// Reset clears config to defaults and all valids; font store content is undefined.
`default_nettype none
module bitmap_glyph_row_renderer #(
  parameter int unsigned FONT_BYTES = 8192,
  parameter int unsigned GLYPH_ROWS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bgrr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bgrr_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             command_i,
  input  wire logic [$clog2(FONT_BYTES)-1:0]    font_addr_i,
  input  wire logic [bgrr_pkg::GLYPH_W-1:0]     font_byte_i,
  input  wire logic [bgrr_pkg::CODE_W-1:0]      char_code_i,
  input  wire logic [bgrr_pkg::POS_W-1:0]       x_pos_i,
  input  wire logic [bgrr_pkg::POS_W-1:0]       y_pos_i,
  input  wire logic [bgrr_pkg::COLOR_W-1:0]     color_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [bgrr_pkg::ADDR_W-1:0]      row_address_o,
  output logic      [bgrr_pkg::GLYPH_W-1:0]     pixel_mask_o,
  output logic      [bgrr_pkg::COLOR_W-1:0]     pixel_color_o,
  output logic                                  last_row_o
);
  import bgrr_pkg::*;

  localparam int unsigned AW = $clog2(FONT_BYTES);

  logic [BASE_W-1:0]   frame_base_q;
  logic [SIZE_W-1:0]   frame_size_q;
  logic [PPL_W-1:0]    ppl_q;
  logic [STRIDE_W-1:0] stride_q;
  cfg_reg_e            cfg_reg;

  logic               adv;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [GLYPH_W-1:0] ram_wdata, ram_rdata;
  row_issue_t         issue;

  assign cfg_reg = cfg_reg_e'(cfg_index_i);
  assign adv     = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= BASE_RST;
      frame_size_q <= SIZE_RST;
      ppl_q        <= PPL_RST;
      stride_q     <= STRIDE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg)
        REG_FRAME_BASE: frame_base_q <= cfg_data_i[BASE_W-1:0];
        REG_FRAME_SIZE: frame_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_PPL:        ppl_q        <= cfg_data_i[PPL_W-1:0];
        REG_STRIDE:     stride_q     <= cfg_data_i[STRIDE_W-1:0];
      endcase
    end
  end

  bgrr_seq #(
    .FONT_BYTES (FONT_BYTES),
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .font_addr_i (font_addr_i),
    .font_byte_i (font_byte_i),
    .char_code_i (char_code_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .color_i     (color_i),
    .stride_i    (stride_q),
    .adv_i       (adv),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .issue_o     (issue)
  );

  bgrr_ram #(
    .Width (GLYPH_W),
    .Depth (FONT_BYTES)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bgrr_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .issue_i       (issue),
    .font_rdata_i  (ram_rdata),
    .frame_base_i  (frame_base_q),
    .frame_size_i  (frame_size_q),
    .ppl_i         (ppl_q),
    .out_valid_o   (out_valid_o),
    .row_address_o (row_address_o),
    .pixel_mask_o  (pixel_mask_o),
    .pixel_color_o (pixel_color_o),
    .last_row_o    (last_row_o)
  );

endmodule
`default_nettype wire

@@ test/bitmap_glyph_row_renderer_test.sv @@
// Self-checking testbench for the glyph row renderer: font loads, glyph draws and frame clipping.
module bitmap_glyph_row_renderer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bgrr_pkg::*;

  localparam int unsigned FONT_BYTES     = 8192;
  localparam int unsigned GLYPH_ROWS     = 16;
  localparam int unsigned FADDR_BITS     = $clog2(FONT_BYTES);
  localparam int unsigned IDLE_PCT       = 19;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 100;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [GLYPH_W-1:0] mask;
    logic [COLOR_W-1:0] color;
    logic               is_last;
  } glyph_row_t;

  class glyph_scoreboard;
    logic [BASE_W-1:0]   frame_base;
    logic [SIZE_W-1:0]   frame_size;
    logic [PPL_W-1:0]    pixels_per_line;
    logic [STRIDE_W-1:0] glyph_stride;
    logic [GLYPH_W-1:0]  font [FONT_BYTES];
    bit                  loaded [FONT_BYTES];
    glyph_row_t          rows_due [$];
    int unsigned         errors, loads, draws, blank_draws, rows_seen;

    function new();
      frame_base      = BASE_RST;
      frame_size      = SIZE_RST;
      pixels_per_line = PPL_RST;
      glyph_stride    = STRIDE_RST;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_FRAME_BASE: frame_base      = value[BASE_W-1:0];
        REG_FRAME_SIZE: frame_size      = value[SIZE_W-1:0];
        REG_PPL:        pixels_per_line = value[PPL_W-1:0];
        REG_STRIDE:     glyph_stride    = value[STRIDE_W-1:0];
      endcase
    endfunction

    function int unsigned glyph_addr(logic [CODE_W-1:0] code, int unsigned r);
      return (32'(code) * 32'(glyph_stride) + r) % FONT_BYTES;
    endfunction

    function bit glyph_ready(logic [CODE_W-1:0] code);
      for (int r = 0; r < GLYPH_ROWS; r++)
        if (!loaded[glyph_addr(code, r)]) return 1'b0;
      return 1'b1;
    endfunction

    function int unsigned pending();
      return rows_due.size();
    endfunction

    function void note_beat(logic cmd, logic [FADDR_BITS-1:0] faddr, logic [GLYPH_W-1:0] fbyte,
                            logic [CODE_W-1:0] code, logic [POS_W-1:0] x,
                            logic [POS_W-1:0] y, logic [COLOR_W-1:0] color);
      logic [63:0]        row_off;
      logic [GLYPH_W-1:0] bits;
      glyph_row_t         row;
      if (cmd == CMD_LOAD) begin
        font[faddr]   = fbyte;
        loaded[faddr] = 1'b1;
        loads++;
        return;
      end
      draws++;
      if (code == '0) begin
        blank_draws++;
        return;
      end
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        bits    = font[glyph_addr(code, r)];
        row_off = 64'(x) * 4 + (64'(y) + 64'(r)) * 64'(pixels_per_line) * 4;
        row.mask = '0;
        // pixels at or past the end of the frame are dropped
        for (int c = 0; c < GLYPH_W; c++)
          if (bits[GLYPH_W-1-c] && (row_off + 64'(c) * 4 < 64'(frame_size)))
            row.mask[GLYPH_W-1-c] = 1'b1;
        row.address = ADDR_W'(64'(frame_base) + row_off);
        row.color   = color;
        row.is_last = (r == GLYPH_ROWS - 1);
        rows_due.push_back(row);
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (row beat %0d)",
                 what, got, want, rows_seen);
    endtask

    task check_row(glyph_row_t got);
      glyph_row_t want;
      rows_seen++;
      if (rows_due.size() == 0) begin
        report_mismatch("unexpected row beat, address", got.address, '0);
        return;
      end
      want = rows_due.pop_front();
      if (got.address !== want.address) report_mismatch("row_address", got.address, want.address);
      if (got.mask !== want.mask)       report_mismatch("pixel_mask", got.mask, want.mask);
      if (got.color !== want.color)     report_mismatch("pixel_color", got.color, want.color);
      if (got.is_last !== want.is_last) report_mismatch("last_row", got.is_last, want.is_last);
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  cfg_reg_e                cfg_index_i = REG_FRAME_BASE;
  logic [CFG_W-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    command_i = CMD_LOAD;
  logic [FADDR_BITS-1:0]   font_addr_i = '0;
  logic [GLYPH_W-1:0]      font_byte_i = '0;
  logic [CODE_W-1:0]       char_code_i = '0;
  logic [POS_W-1:0]        x_pos_i = '0;
  logic [POS_W-1:0]        y_pos_i = '0;
  logic [COLOR_W-1:0]      color_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [ADDR_W-1:0]       row_address_o;
  logic [GLYPH_W-1:0]      pixel_mask_o;
  logic [COLOR_W-1:0]      pixel_color_o;
  logic                    last_row_o;

  glyph_scoreboard sb = new();
  bit              idle_on = 1'b1;
  int unsigned     beats_sent = 0;
  int unsigned     settings_used = 1;
  int unsigned     quiet_cycles = 0;

  bitmap_glyph_row_renderer #(
    .FONT_BYTES(FONT_BYTES),
    .GLYPH_ROWS(GLYPH_ROWS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .font_addr_i  (font_addr_i),
    .font_byte_i  (font_byte_i),
    .char_code_i  (char_code_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .color_i      (color_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_address_o(row_address_o),
    .pixel_mask_o (pixel_mask_o),
    .pixel_color_o(pixel_color_o),
    .last_row_o   (last_row_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // beat monitor, row checker and watchdog
  always @(posedge clk_i) begin
    bit         moved;
    glyph_row_t got;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_beat(command_i, font_addr_i, font_byte_i, char_code_i, x_pos_i, y_pos_i,
                     color_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{row_address_o, pixel_mask_o, pixel_color_o, last_row_o};
        sb.check_row(got);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_beat(logic cmd, logic [FADDR_BITS-1:0] faddr, logic [GLYPH_W-1:0] fbyte,
                           logic [CODE_W-1:0] code, logic [POS_W-1:0] x,
                           logic [POS_W-1:0] y, logic [COLOR_W-1:0] color);
    @(negedge clk_i);
    while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    font_addr_i <= faddr;
    font_byte_i <= fbyte;
    char_code_i <= code;
    x_pos_i     <= x;
    y_pos_i     <= y;
    color_i     <= color;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic load_font(logic [FADDR_BITS-1:0] faddr, logic [GLYPH_W-1:0] fbyte);
    send_beat(CMD_LOAD, faddr, fbyte, CODE_W'($urandom), POS_W'($urandom), POS_W'($urandom),
              $urandom);
  endtask

  task automatic load_glyph(logic [CODE_W-1:0] code);
    int unsigned        pick;
    logic [GLYPH_W-1:0] pattern;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      pick    = $urandom_range(99);
      pattern = (pick < 15) ? '1 : (pick < 30) ? '0 : GLYPH_W'($urandom);
      load_font(FADDR_BITS'(sb.glyph_addr(code, r)), pattern);
    end
  endtask

  task automatic draw_glyph(logic [CODE_W-1:0] code);
    logic [POS_W-1:0] x, y;
    if ($urandom_range(1) == 1) begin
      x = POS_W'($urandom);
      y = POS_W'($urandom);
    end else begin
      x = POS_W'($urandom_range(1100));
      y = POS_W'($urandom_range(300));
    end
    send_beat(CMD_DRAW, FADDR_BITS'($urandom), GLYPH_W'($urandom), code, x, y, $urandom);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    sb.set_reg(idx, value);
  endtask

  task automatic program_frame(logic [CFG_W-1:0] base, logic [CFG_W-1:0] size,
                               logic [CFG_W-1:0] ppl, logic [CFG_W-1:0] stride);
    write_reg(REG_FRAME_BASE, base);
    write_reg(REG_FRAME_SIZE, size);
    write_reg(REG_PPL, ppl);
    write_reg(REG_STRIDE, stride);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // hold the sender until every row is out, then let loads and blank draws settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned       goal, sel;
    logic [CODE_W-1:0] code;
    goal = beats_sent + n;
    while (beats_sent < goal) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        load_font(FADDR_BITS'($urandom_range(FONT_BYTES - 1)), GLYPH_W'($urandom));
      end else if (sel < 23) begin
        draw_glyph('0);
      end else begin
        code = ($urandom_range(9) == 0) ? '1 : CODE_W'($urandom_range(255, 1));
        // mostly reuse a glyph already in the store
        if (sel >= 40)
          for (int k = 0; k < 255 && !sb.glyph_ready(code); k++)
            code = (code == '1) ? CODE_W'(1) : code + CODE_W'(1);
        if (sel < 40 || !sb.glyph_ready(code)) load_glyph(code);
        draw_glyph(code);
      end
    end
  endtask

  initial begin
    int unsigned        ppl;
    logic [GLYPH_W-1:0] pattern;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, on reset settings
    load_font('0, '0);
    load_font('1, '1);
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      case (r)
        0:       pattern = '1;
        1:       pattern = 8'h80;
        2:       pattern = 8'h01;
        3:       pattern = '0;
        default: pattern = GLYPH_W'($urandom);
      endcase
      load_font(FADDR_BITS'(sb.glyph_addr(CODE_W'(1), r)), pattern);
    end
    send_beat(CMD_DRAW, '1, '1, CODE_W'(1), '0, '0, '0);
    send_beat(CMD_DRAW, '0, '0, '0, POS_W'($urandom), POS_W'($urandom), '1);
    send_beat(CMD_DRAW, '1, '0, CODE_W'(1), '1, '1, '1);
    send_beat(CMD_DRAW, '0, '1, CODE_W'(1), POS_W'(1020), POS_W'(1015), $urandom);

    drain();
    program_frame('1, CFG_W'(1 << 28), CFG_W'(8192), CFG_W'(32));
    random_phase(45);

    drain();
    program_frame('0, '0, CFG_W'(1), CFG_W'(16));
    random_phase(30);

    drain();
    program_frame(CFG_W'({$urandom, $urandom}), CFG_W'($urandom_range(1 << 28)), '0,
                  CFG_W'(24));
    random_phase(30);

    // frame end falls inside the small position window; no idling on either side
    drain();
    ppl = $urandom_range(1100, 16);
    program_frame(CFG_W'({$urandom, $urandom}),
                  CFG_W'(ppl * 4 * $urandom_range(250, 1) + $urandom_range(ppl * 4)),
                  CFG_W'(ppl), CFG_W'($urandom_range(32, 16)));
    idle_on = 1'b0;
    random_phase(60);
    idle_on = 1'b1;

    drain();
    program_frame(CFG_W'({$urandom, $urandom}), CFG_W'($urandom_range(1 << 28)),
                  CFG_W'($urandom_range(8192, 1)), CFG_W'($urandom_range(32, 16)));
    random_phase(20);
    drain();
    random_phase(20);
    drain();

    $display("Run covered %0d font loads and %0d draws (%0d with code zero) over %0d settings",
             sb.loads, sb.draws, sb.blank_draws, settings_used);
    $display("%0d glyph rows checked, %0d mismatches", sb.rows_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
